@@ rtl/vbw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vbw_pkg
// Shared widths, defaults, action codes and entry layout helpers for the
// vertex bone weight table.
// ----------------------------------------------------------------------------
package vbw_pkg;

    localparam int VERTEX_COUNT_DEF = 4096;
    localparam int SLOTS_DEF        = 4;

    localparam int VID_W      = 12;
    localparam int BONE_W     = 8;
    localparam int WEIGHT_W   = 16;
    localparam int COUNT_O_W  = 3;
    localparam int OUT_SLOTS  = 4;

    typedef enum logic {
        ACT_ADD  = 1'b0,
        ACT_READ = 1'b1
    } action_t;

    // fill count field width for a given slot count
    function automatic int cnt_w(input int slots);
        return $clog2(slots + 1);
    endfunction

    // packed entry: count, then bones, then weights
    function automatic int entry_w(input int slots);
        return cnt_w(slots) + slots * (BONE_W + WEIGHT_W);
    endfunction

endpackage

`default_nettype wire

@@ rtl/vertex_bone_weight_top4_table.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_bone_weight_top4_table
// Per-vertex table of the strongest bone influences, with add and read
// transactions over a single read-modify-write memory.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while the result side keeps up. Each
// transaction reads the vertex entry from one synchronous memory (count,
// bones, weights packed in one word) at acceptance, updates it in the
// following cycle and writes it back; a back-to-back transaction to the same
// vertex gets the fresh entry from a forwarding register. A read presents its
// result in the output register after the update stage; an add returns
// nothing. A read whose result cannot enter the output register waits in
// the update stage with s_ready low until m_ready frees it. After reset the
// block sweeps the memory to zero, one entry per cycle, with s_ready low
// until the last entry is cleared; bone_base writes are taken at any time.
module vertex_bone_weight_top4_table #(
    parameter int VERTEX_COUNT = vbw_pkg::VERTEX_COUNT_DEF,
    parameter int SLOTS        = vbw_pkg::SLOTS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [vbw_pkg::BONE_W-1:0]      cfg_data,

    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic                            s_action,
    input  wire logic [vbw_pkg::VID_W-1:0]       s_vertex_id,
    input  wire logic [vbw_pkg::BONE_W-1:0]      s_bone,
    input  wire logic [vbw_pkg::WEIGHT_W-1:0]    s_weight,

    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic      [vbw_pkg::COUNT_O_W-1:0]   m_slot_count,
    output logic      [vbw_pkg::BONE_W-1:0]      m_bone_0,
    output logic      [vbw_pkg::BONE_W-1:0]      m_bone_1,
    output logic      [vbw_pkg::BONE_W-1:0]      m_bone_2,
    output logic      [vbw_pkg::BONE_W-1:0]      m_bone_3,
    output logic      [vbw_pkg::WEIGHT_W-1:0]    m_weight_0,
    output logic      [vbw_pkg::WEIGHT_W-1:0]    m_weight_1,
    output logic      [vbw_pkg::WEIGHT_W-1:0]    m_weight_2,
    output logic      [vbw_pkg::WEIGHT_W-1:0]    m_weight_3
);
    import vbw_pkg::*;

    localparam int ADDR_W   = $clog2(VERTEX_COUNT);
    localparam int CNT_W    = cnt_w(SLOTS);
    localparam int ENTRY_W  = entry_w(SLOTS);
    localparam int BONE_LSB = CNT_W;
    localparam int WGT_LSB  = CNT_W + SLOTS * BONE_W;

    // configuration
    logic [BONE_W-1:0] bone_base_reg;

    // clearing sweep
    logic              clr_active_reg, clr_active_next;
    logic [ADDR_W-1:0] clr_addr_reg,   clr_addr_next;

    // update stage
    logic               st1_valid_reg, st1_valid_next;
    action_t            st1_action_reg;
    logic               st1_inrange_reg;
    logic [ADDR_W-1:0]  st1_addr_reg;
    logic [BONE_W-1:0]  st1_bone_reg;
    logic [WEIGHT_W-1:0] st1_weight_reg;
    logic               st1_fwd_hit_reg;
    logic [ENTRY_W-1:0] st1_fwd_data_reg;

    // output register
    logic                              m_valid_reg, m_valid_next;
    logic [COUNT_O_W-1:0]              m_count_reg;
    logic [OUT_SLOTS-1:0][BONE_W-1:0]  m_bone_reg;
    logic [OUT_SLOTS-1:0][WEIGHT_W-1:0] m_weight_reg;

    logic               s_accept;
    logic               out_busy;
    logic               st1_stall;
    logic               st1_emit;
    logic               wr_en_item;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_inrange;
    logic [ENTRY_W-1:0] mem_rdata;
    logic [ENTRY_W-1:0] st1_entry;
    logic [ENTRY_W-1:0] new_entry;
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;

    logic [OUT_SLOTS-1:0][BONE_W-1:0]   view_bone;
    logic [OUT_SLOTS-1:0][WEIGHT_W-1:0] view_weight;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bone_base_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            bone_base_reg <= cfg_data;
        end
    end

    // handshake control
    assign out_busy   = m_valid_reg && !m_ready;
    assign st1_stall  = st1_valid_reg && (st1_action_reg == ACT_READ) && out_busy;
    assign st1_emit   = st1_valid_reg && (st1_action_reg == ACT_READ) && !out_busy;
    assign s_ready    = !clr_active_reg && !st1_stall;
    assign s_accept   = s_valid && s_ready;
    assign rd_addr    = ADDR_W'(s_vertex_id);
    assign rd_inrange = (32'(s_vertex_id) < 32'(VERTEX_COUNT));

    assign st1_entry  = st1_fwd_hit_reg ? st1_fwd_data_reg : mem_rdata;
    assign wr_en_item = st1_valid_reg && (st1_action_reg == ACT_ADD) && st1_inrange_reg;

    assign mem_we    = clr_active_reg || wr_en_item;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : st1_addr_reg;
    assign mem_wdata = clr_active_reg ? '0 : new_entry;

    vbw_mem #(
        .DEPTH  (VERTEX_COUNT),
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_mem (
        .clk   (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (s_accept),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    vbw_update #(
        .SLOTS   (SLOTS),
        .ENTRY_W (ENTRY_W)
    ) u_update (
        .entry_in  (st1_entry),
        .bone      (st1_bone_reg),
        .weight    (st1_weight_reg),
        .entry_out (new_entry)
    );

    // clearing sweep after reset
    always_comb begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg) begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(VERTEX_COUNT - 1)) begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_comb begin
        st1_valid_next = st1_valid_reg;
        if (s_accept) begin
            st1_valid_next = 1'b1;
        end else if (!st1_stall) begin
            st1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (st1_emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            st1_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            st1_valid_reg  <= st1_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // transaction payload; the forward captures the write landing this edge
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            st1_action_reg   <= action_t'(s_action);
            st1_inrange_reg  <= rd_inrange;
            st1_addr_reg     <= rd_addr;
            st1_bone_reg     <= s_bone + bone_base_reg;
            st1_weight_reg   <= s_weight;
            st1_fwd_hit_reg  <= wr_en_item && (st1_addr_reg == rd_addr);
            st1_fwd_data_reg <= new_entry;
        end
    end

    // slots beyond SLOTS read zero
    for (genvar o = 0; o < OUT_SLOTS; o++) begin : g_view
        if (o < SLOTS) begin : g_used
            assign view_bone[o]   = st1_entry[BONE_LSB + o*BONE_W +: BONE_W];
            assign view_weight[o] = st1_entry[WGT_LSB + o*WEIGHT_W +: WEIGHT_W];
        end else begin : g_unused
            assign view_bone[o]   = '0;
            assign view_weight[o] = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st1_emit) begin
            if (st1_inrange_reg) begin
                m_count_reg  <= COUNT_O_W'(st1_entry[CNT_W-1:0]);
                m_bone_reg   <= view_bone;
                m_weight_reg <= view_weight;
            end else begin
                m_count_reg  <= '0;
                m_bone_reg   <= '0;
                m_weight_reg <= '0;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_slot_count = m_count_reg;
    assign m_bone_0     = m_bone_reg[0];
    assign m_bone_1     = m_bone_reg[1];
    assign m_bone_2     = m_bone_reg[2];
    assign m_bone_3     = m_bone_reg[3];
    assign m_weight_0   = m_weight_reg[0];
    assign m_weight_1   = m_weight_reg[1];
    assign m_weight_2   = m_weight_reg[2];
    assign m_weight_3   = m_weight_reg[3];

    // item writes never overlap the clearing sweep
    a_no_item_write_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en_item |-> !clr_active_reg)
        else $error("item write during clearing sweep");

    // same vertex back to back must take the forwarded entry
    a_forward_taken: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && wr_en_item && (st1_addr_reg == rd_addr)) |=> st1_fwd_hit_reg)
        else $error("missed forward on back-to-back vertex");

    // a read in the update stage with a free output register yields a result
    a_read_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_emit |=> m_valid_reg)
        else $error("read transaction dropped");

    // fill count of a live entry never exceeds the slot count
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (st1_valid_reg && st1_inrange_reg) |-> (st1_entry[CNT_W-1:0] <= CNT_W'(SLOTS)))
        else $error("fill count out of range");

endmodule

`default_nettype wire

@@ rtl/vbw_mem.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vbw_mem
// Simple dual-port synchronous memory, one write and one registered read
// port. Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module vbw_mem #(
    parameter int DEPTH  = vbw_pkg::VERTEX_COUNT_DEF,
    parameter int ADDR_W = $clog2(vbw_pkg::VERTEX_COUNT_DEF),
    parameter int DATA_W = vbw_pkg::entry_w(vbw_pkg::SLOTS_DEF)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/vbw_update.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// vbw_update
// Slot update of one vertex entry: fill the next free slot, or replace the
// weakest slot (lowest index on ties) when the new weight is strictly larger.
// ----------------------------------------------------------------------------
module vbw_update #(
    parameter int SLOTS   = vbw_pkg::SLOTS_DEF,
    parameter int ENTRY_W = vbw_pkg::entry_w(vbw_pkg::SLOTS_DEF)
) (
    input  wire logic [ENTRY_W-1:0]           entry_in,
    input  wire logic [vbw_pkg::BONE_W-1:0]   bone,
    input  wire logic [vbw_pkg::WEIGHT_W-1:0] weight,
    output logic      [ENTRY_W-1:0]           entry_out
);
    import vbw_pkg::*;

    localparam int CNT_W   = cnt_w(SLOTS);
    localparam int SIDX_W  = $clog2(SLOTS);
    localparam int BONE_LSB = CNT_W;
    localparam int WGT_LSB  = CNT_W + SLOTS * BONE_W;

    logic [CNT_W-1:0]                cnt;
    logic [SLOTS-1:0][WEIGHT_W-1:0]  wts;
    logic [SIDX_W-1:0]               low_idx;
    logic [WEIGHT_W-1:0]             low_w;
    logic                            full;

    always_comb begin
        cnt = entry_in[CNT_W-1:0];
        for (int s = 0; s < SLOTS; s++) begin
            wts[s] = entry_in[WGT_LSB + s*WEIGHT_W +: WEIGHT_W];
        end

        // weakest slot, strict compare keeps the lowest index on ties
        low_idx = '0;
        low_w   = wts[0];
        for (int s = 1; s < SLOTS; s++) begin
            if (wts[s] < low_w) begin
                low_idx = SIDX_W'(s);
                low_w   = wts[s];
            end
        end

        full      = (cnt >= CNT_W'(SLOTS));
        entry_out = entry_in;
        if (!full) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (cnt == CNT_W'(s)) begin
                    entry_out[BONE_LSB + s*BONE_W +: BONE_W]   = bone;
                    entry_out[WGT_LSB + s*WEIGHT_W +: WEIGHT_W] = weight;
                end
            end
            entry_out[CNT_W-1:0] = cnt + CNT_W'(1);
        end else if (weight > low_w) begin
            for (int s = 0; s < SLOTS; s++) begin
                if (low_idx == SIDX_W'(s)) begin
                    entry_out[BONE_LSB + s*BONE_W +: BONE_W]   = bone;
                    entry_out[WGT_LSB + s*WEIGHT_W +: WEIGHT_W] = weight;
                end
            end
        end
    end

endmodule

`default_nettype wire
